>>> rtl/kvp_pkg.sv
// Shared types and constants of the key-value command line parser.
`default_nettype none
package kvp_pkg;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BAD_CMD  = 3'd1,
        ST_BAD_LEN  = 3'd2,
        ST_BAD_EXP  = 3'd3,
        ST_TOO_LONG = 3'd4
    } kvp_status_t;

    // Recognised commands
    typedef enum logic [2:0] {
        M_NONE   = 3'd0,
        M_GET    = 3'd1,
        M_ADD    = 3'd2,
        M_SET    = 3'd3,
        M_DELETE = 3'd4
    } kvp_method_t;

    // Configuration register indexes
    localparam logic [1:0] CFG_LONG_LINE  = 2'd0;
    localparam logic [1:0] CFG_LEAD_SPACE = 2'd1;

    localparam logic [11:0] LONG_LINE_RST  = 12'd1024;
    localparam logic [11:0] LEAD_SPACE_RST = 12'd100;

    // Command words, last character in the lowest byte
    localparam logic [47:0] CMD_GET    = 48'h676574;
    localparam logic [47:0] CMD_ADD    = 48'h616464;
    localparam logic [47:0] CMD_SET    = 48'h736574;
    localparam logic [47:0] CMD_GETEX  = 48'h6765746578;
    localparam logic [47:0] CMD_DELETE = 48'h64656C657465;

    localparam logic [32:0] COUNT_LIM  = 33'h0FFFFFFFD;
    localparam logic [32:0] EXPIRY_LIM = 33'h0FFFFFFFF;
    localparam logic [13:0] HDR_BASE   = 14'd23;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Per-line parse state
    typedef struct packed {
        logic [3:0]  token_index;
        logic [11:0] token_start;
        logic        in_token;
        logic [47:0] command_chars;
        logic [2:0]  command_length;
        logic [11:0] key_offset;
        logic [11:0] key_length;
        logic [11:0] flags_offset;
        logic [11:0] flags_length;
        logic [32:0] count_acc;
        logic [11:0] count_length;
        logic [32:0] expiry_acc;
        logic [1:0]  num_err;
        logic [11:0] leading_spaces;
        logic        nul_seen;
        logic        get_exempt;
    } kvp_state_t;

    // One result item
    typedef struct packed {
        kvp_status_t status;
        kvp_method_t method;
        logic [11:0] key_offset;
        logic [11:0] key_length;
        logic [11:0] flags_offset;
        logic [11:0] flags_length;
        logic [31:0] value_length;
        logic [31:0] expire_time;
        logic [13:0] header_length;
        logic [11:0] line_length;
    } kvp_result_t;

endpackage
`default_nettype wire

>>> rtl/kvp_line_judge.sv
// Judges a finished line: command decode, field selection and result arithmetic.
`default_nettype none
module kvp_line_judge
    import kvp_pkg::*;
(
    input  kvp_state_t  st,
    input  logic [31:0] now_time,
    input  logic [11:0] line_length,
    output kvp_result_t res
);

    kvp_method_t method;
    logic        add_set;

    // Command decode
    always_comb begin
        method = M_NONE;
        case (st.command_length)
            3'd3: begin
                if (st.command_chars == CMD_GET) method = M_GET;
                else if (st.command_chars == CMD_ADD) method = M_ADD;
                else if (st.command_chars == CMD_SET) method = M_SET;
            end
            3'd5: begin
                if (st.command_chars == CMD_GETEX) method = M_GET;
            end
            3'd6: begin
                if (st.command_chars == CMD_DELETE) method = M_DELETE;
            end
            default: method = M_NONE;
        endcase
        if (st.token_index == 4'd0) method = M_NONE;
    end

    assign add_set = (method == M_ADD) || (method == M_SET);

    // Field selection
    always_comb begin
        res = '0;
        res.status      = ST_BAD_CMD;
        res.method      = method;
        res.line_length = line_length;
        if (method != M_NONE) begin
            res.status = ST_OK;
            if (st.token_index >= 4'd2) begin
                res.key_offset = st.key_offset;
                res.key_length = st.key_length;
            end
            if (add_set) begin
                if (st.token_index < 4'd5) begin
                    res.status = ST_BAD_CMD;
                end else begin
                    res.flags_offset  = st.flags_offset;
                    res.flags_length  = st.flags_length;
                    res.header_length = {2'b0, st.key_length} + {2'b0, st.flags_length}
                                      + {2'b0, st.count_length} + HDR_BASE;
                    if (st.num_err[0]) begin
                        res.status = ST_BAD_LEN;
                    end else begin
                        res.value_length = st.count_acc[31:0] + 32'd2;
                        if (st.num_err[1]) res.status = ST_BAD_EXP;
                        else if (st.expiry_acc != '0)
                            res.expire_time = st.expiry_acc[31:0] + now_time;
                    end
                end
            end
        end
    end

endmodule
`default_nettype wire

>>> rtl/kv_ascii_command_parser_unit.sv
// Top level of the key-value ASCII command line parser.
`default_nettype none
// Takes one byte of a command line per transfer and gives one result per line on LF,
// or an early "line too long" result. Every byte passes an input register and the
// parse logic into the result register, so a byte can be taken every cycle while
// results are taken; a result reaches the master side from the result register.
// A byte waits in the input register while an earlier result waits to be taken, so
// the slave side stalls for as long as the master side holds off with a result held.
module kv_ascii_command_parser_unit
    import kvp_pkg::*;
#(
    parameter int MAX_TOKENS = 8,
    parameter int MAX_LINE   = 4096
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [39:0]  s_tdata,   // char_in[7:0], now_time[39:8]
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // status[2:0], method[5:3], key_offset[17:6], key_length[29:18],
    // flags_offset[41:30], flags_length[53:42], value_length[85:54],
    // expire_time[117:86], header_length[131:118], line_length[143:132]
    output logic [143:0]      m_tdata,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [11:0]  cfg_data
);

    localparam logic [11:0] POS_CAP = 12'((MAX_LINE - 1) < 4095 ? (MAX_LINE - 1) : 4095);
    localparam logic [3:0]  TI_MAX  = 4'(MAX_TOKENS - 1);

    logic [11:0] long_limit_reg, lead_limit_reg;
    logic        in_valid_reg;
    logic [7:0]  char_reg;
    logic [31:0] now_reg;
    kvp_state_t  st_reg, st_next;
    logic [11:0] pos_reg, pos_next;
    logic        prev_cr_reg, prev_cr_next;
    kvp_result_t res_reg, res_next;
    logic        out_valid_reg;
    logic        fire, emit;
    logic [11:0] pos_inc;
    kvp_state_t  lf_s1, lf_s2, nl_s1, nl_s2;
    logic [11:0] lf_end;
    kvp_result_t judge_res;

    // Close the open token at the given end position
    function automatic kvp_state_t end_token(kvp_state_t s, logic [11:0] end_pos);
        logic [11:0] len;
        len = (end_pos > s.token_start) ? end_pos - s.token_start : 12'd0;
        case (s.token_index)
            4'd1: begin
                s.key_offset = s.token_start;
                s.key_length = len;
            end
            4'd2: begin
                s.flags_offset = s.token_start;
                s.flags_length = len;
            end
            4'd4: s.count_length = len;
            default: ;
        endcase
        if (s.token_index < TI_MAX) s.token_index = s.token_index + 4'd1;
        s.in_token = 1'b0;
        return s;
    endfunction

    // One decimal digit into an accumulator; bit 33 flags an error
    function automatic logic [33:0] take_digit(logic [32:0] acc, logic [7:0] c,
                                               logic [32:0] lim);
        logic [36:0] prod;
        prod = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {29'b0, 8'(c - 8'h30)};
        if (c < 8'h30 || c > 8'h39) return {1'b1, acc};
        if (prod > {4'b0, lim}) return {1'b1, lim + 33'd1};
        return {1'b0, prod[32:0]};
    endfunction

    // Feed one content byte into the parse state
    function automatic kvp_state_t feed(kvp_state_t s, logic [7:0] c, logic [11:0] p);
        logic [33:0] d;
        d = '0;
        if (!s.nul_seen) begin
            if (c == CH_NUL) begin
                if (s.in_token) s = end_token(s, p);
                s.nul_seen = 1'b1;
            end else if (c == CH_SPACE) begin
                if (s.in_token) begin
                    if (s.token_index == 4'd0 && s.command_length == 3'd3 &&
                        s.command_chars == CMD_GET)
                        s.get_exempt = 1'b1;
                    s = end_token(s, p);
                end else if (s.token_index == 4'd0 && s.leading_spaces < 12'd4095) begin
                    s.leading_spaces = s.leading_spaces + 12'd1;
                end
            end else begin
                if (!s.in_token) begin
                    s.in_token    = 1'b1;
                    s.token_start = p;
                end
                if (s.token_index == 4'd0) begin
                    if (s.command_length < 3'd7) s.command_length = s.command_length + 3'd1;
                    if (s.command_length <= 3'd6) s.command_chars = {s.command_chars[39:0], c};
                end else if (s.token_index == 4'd3) begin
                    d = take_digit(s.expiry_acc, c, EXPIRY_LIM);
                    s.num_err[1] = s.num_err[1] | d[33];
                    s.expiry_acc = d[32:0];
                end else if (s.token_index == 4'd4) begin
                    d = take_digit(s.count_acc, c, COUNT_LIM);
                    s.num_err[0] = s.num_err[0] | d[33];
                    s.count_acc  = d[32:0];
                end
            end
        end
        return s;
    endfunction

    // Handshakes
    assign fire      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || fire;
    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            long_limit_reg <= LONG_LINE_RST;
            lead_limit_reg <= LEAD_SPACE_RST;
        end else if (cfg_valid) begin
            if (cfg_index == CFG_LONG_LINE) long_limit_reg <= cfg_data;
            else if (cfg_index == CFG_LEAD_SPACE) lead_limit_reg <= cfg_data;
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (fire) begin
            in_valid_reg <= 1'b0;
        end
        if (s_tvalid && s_tready) begin
            char_reg <= s_tdata[7:0];
            now_reg  <= s_tdata[39:8];
        end
    end

    // Line end path: resolve a pending CR, close the last token
    assign pos_inc = (pos_reg < POS_CAP) ? pos_reg + 12'd1 : POS_CAP;
    assign lf_s1   = (prev_cr_reg && pos_reg < 12'd2) ? feed(st_reg, CH_CR, 12'd0) : st_reg;
    assign lf_end  = (prev_cr_reg && pos_reg >= 12'd2) ? pos_reg - 12'd1 : pos_reg;
    assign lf_s2   = (lf_s1.in_token && !lf_s1.nul_seen) ? end_token(lf_s1, lf_end) : lf_s1;

    kvp_line_judge u_judge (
        .st          (lf_s2),
        .now_time    (now_reg),
        .line_length (pos_inc),
        .res         (judge_res)
    );

    // Ordinary byte path: a held CR is fed before the new byte
    assign nl_s1 = prev_cr_reg
                 ? feed(st_reg, CH_CR, (pos_reg > 12'd0) ? pos_reg - 12'd1 : 12'd0)
                 : st_reg;
    assign nl_s2 = (char_reg == CH_CR) ? nl_s1 : feed(nl_s1, char_reg, pos_reg);

    // Next state and result
    always_comb begin
        st_next      = st_reg;
        pos_next     = pos_reg;
        prev_cr_next = prev_cr_reg;
        res_next     = res_reg;
        emit         = 1'b0;
        if (fire) begin
            if (char_reg == CH_LF) begin
                emit         = 1'b1;
                res_next     = judge_res;
                st_next      = '0;
                pos_next     = '0;
                prev_cr_next = 1'b0;
            end else begin
                st_next      = nl_s2;
                pos_next     = pos_inc;
                prev_cr_next = (char_reg == CH_CR);
                if (pos_inc > long_limit_reg &&
                    !(nl_s2.get_exempt && nl_s2.leading_spaces <= lead_limit_reg)) begin
                    emit                 = 1'b1;
                    res_next             = '0;
                    res_next.status      = ST_TOO_LONG;
                    res_next.method      = M_NONE;
                    res_next.line_length = pos_inc;
                    st_next              = '0;
                    pos_next             = '0;
                    prev_cr_next         = 1'b0;
                end
            end
        end
    end

    // Parse state and result registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg        <= '0;
            pos_reg       <= '0;
            prev_cr_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            st_reg      <= st_next;
            pos_reg     <= pos_next;
            prev_cr_reg <= prev_cr_next;
            if (emit) out_valid_reg <= 1'b1;
            else if (m_tready) out_valid_reg <= 1'b0;
        end
        if (emit) res_reg <= res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {res_reg.line_length, res_reg.header_length, res_reg.expire_time,
                       res_reg.value_length, res_reg.flags_length, res_reg.flags_offset,
                       res_reg.key_length, res_reg.key_offset, res_reg.method,
                       res_reg.status};

`ifndef SYNTH
    // An early rejection carries no command
    a_long_no_method: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && res_reg.status == ST_TOO_LONG) |-> res_reg.method == M_NONE)
        else $error("too-long result with a method");

    // An unknown command is only ever reported as bad command or too long
    a_none_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && res_reg.method == M_NONE) |->
        (res_reg.status == ST_BAD_CMD || res_reg.status == ST_TOO_LONG))
        else $error("invalid method with unexpected status");

    // A byte count is only given for add and set
    a_value_addset: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && res_reg.value_length != 32'd0) |->
        (res_reg.method == M_ADD || res_reg.method == M_SET))
        else $error("value length without add or set");

    // After a result is produced the parse state starts afresh
    a_clear_after_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |=> (pos_reg == 12'd0 && !prev_cr_reg))
        else $error("line state not cleared after result");
`endif

endmodule
`default_nettype wire
